// ===== src/psc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and codes of the polyline segment collision block
package psc_pkg;

	localparam int MAX_SHIP_POINTS = 16;
	localparam int MAX_LAND_POINTS = 256;
	localparam int COORD_BITS      = 16;

	localparam int SHIP_AW = $clog2(MAX_SHIP_POINTS);
	localparam int SHIP_CW = $clog2(MAX_SHIP_POINTS + 1);
	localparam int LAND_AW = $clog2(MAX_LAND_POINTS);
	localparam int LAND_CW = $clog2(MAX_LAND_POINTS + 1);

	// coordinate, coordinate difference, product, cross product, difference of crosses
	typedef logic signed [COORD_BITS-1:0]   coord_t;
	typedef logic signed [COORD_BITS:0]     rel_t;
	typedef logic signed [2*COORD_BITS+1:0] prod_t;
	typedef logic signed [2*COORD_BITS+2:0] cross_t;
	typedef logic signed [2*COORD_BITS+3:0] den_t;

	typedef enum logic [1:0] {
		CMD_SHIP = 2'd0,
		CMD_LAND = 2'd1,
		CMD_EVAL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SA_RD,
		ST_SB_RD,
		ST_SB_WT,
		ST_L_RD,
		ST_L_WT,
		ST_SD1,
		ST_SD2,
		ST_SD3,
		ST_CAP,
		ST_CC1,
		ST_CC2,
		ST_CC3,
		ST_EV1,
		ST_EV2,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    mul_en;
		acc_op_t acc_op;
	} mac_ctrl_t;

	typedef struct packed {
		logic wr_ship;
		logic wr_land;
		logic clear;
	} store_ctrl_t;

	typedef struct packed {
		logic [SHIP_CW-1:0] ship_count;
		logic [LAND_CW-1:0] land_count;
		logic               dropped;
	} store_stat_t;

endpackage

// ===== src/psc_if.sv =====
`timescale 1ns / 1ps
// valid/ready channels for vertex requests and collision results
interface psc_in_if import psc_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [1:0]   command;
	coord_t       x_coord;
	coord_t       y_coord;

	modport source (output valid, output command, output x_coord, output y_coord,
		input ready);
	modport sink (input valid, input command, input x_coord, input y_coord,
		output ready);
endinterface

interface psc_out_if import psc_pkg::*; ();
	logic valid;
	logic ready;
	logic hit;
	logic overflow;

	modport source (output valid, output hit, output overflow, input ready);
	modport sink (input valid, input hit, input overflow, output ready);
endinterface

// ===== src/psc_store.sv =====
`timescale 1ns / 1ps
// ship and landscape vertex memories with fill counts and drop flag
module psc_store import psc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  store_ctrl_t        ctrl,
	input  coord_t             wr_x,
	input  coord_t             wr_y,
	input  logic [SHIP_AW-1:0] ship_raddr,
	input  logic [LAND_AW-1:0] land_raddr,
	output coord_t             ship_rx,
	output coord_t             ship_ry,
	output coord_t             land_rx,
	output coord_t             land_ry,
	output store_stat_t        stat
);

	coord_t ship_x_q [MAX_SHIP_POINTS];
	coord_t ship_y_q [MAX_SHIP_POINTS];
	coord_t land_x_q [MAX_LAND_POINTS];
	coord_t land_y_q [MAX_LAND_POINTS];

	logic [SHIP_CW-1:0] ship_count_q;
	logic [LAND_CW-1:0] land_count_q;
	logic               dropped_q;
	coord_t             ship_rx_q, ship_ry_q, land_rx_q, land_ry_q;

	logic ship_full, land_full;

	assign ship_full = (ship_count_q == SHIP_CW'(MAX_SHIP_POINTS));
	assign land_full = (land_count_q == LAND_CW'(MAX_LAND_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ship_count_q <= '0;
			land_count_q <= '0;
			dropped_q    <= 1'b0;
		end else if (ctrl.clear) begin
			ship_count_q <= '0;
			land_count_q <= '0;
			dropped_q    <= 1'b0;
		end else begin
			if (ctrl.wr_ship) begin
				if (ship_full) begin
					dropped_q <= 1'b1;
				end else begin
					ship_count_q <= ship_count_q + SHIP_CW'(1);
				end
			end
			if (ctrl.wr_land) begin
				if (land_full) begin
					dropped_q <= 1'b1;
				end else begin
					land_count_q <= land_count_q + LAND_CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_ship && !ship_full) begin
			ship_x_q[ship_count_q[SHIP_AW-1:0]] <= wr_x;
			ship_y_q[ship_count_q[SHIP_AW-1:0]] <= wr_y;
		end
		ship_rx_q <= ship_x_q[ship_raddr];
		ship_ry_q <= ship_y_q[ship_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_land && !land_full) begin
			land_x_q[land_count_q[LAND_AW-1:0]] <= wr_x;
			land_y_q[land_count_q[LAND_AW-1:0]] <= wr_y;
		end
		land_rx_q <= land_x_q[land_raddr];
		land_ry_q <= land_y_q[land_raddr];
	end

	assign ship_rx = ship_rx_q;
	assign ship_ry = ship_ry_q;
	assign land_rx = land_rx_q;
	assign land_ry = land_ry_q;

	assign stat.ship_count = ship_count_q;
	assign stat.land_count = land_count_q;
	assign stat.dropped    = dropped_q;

endmodule

// ===== src/psc_mac.sv =====
`timescale 1ns / 1ps
// shared signed multiplier with product register and subtracting accumulator
module psc_mac import psc_pkg::*; (
	input  logic      clk,
	input  mac_ctrl_t ctrl,
	input  rel_t      op_a,
	input  rel_t      op_b,
	output cross_t    acc
);

	prod_t  prod_q;
	cross_t acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod_t'(op_a) * prod_t'(op_b);
		end
		unique case (ctrl.acc_op)
			ACC_LOAD: acc_q <= cross_t'(prod_q);
			ACC_SUB:  acc_q <= acc_q - cross_t'(prod_q);
			default:  acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

// ===== src/polyline_segment_collision_core.sv =====
`timescale 1ns / 1ps
// top level: vertex loading and segment pair sequencer around one multiplier
//
//  channel  | dir | payload                       | note
//  ---------+-----+-------------------------------+------------------------------
//  vertex   | in  | command, x_coord, y_coord     | load ship, load land, evaluate
//  result   | out | hit, overflow                 | one result per evaluate
//
// loads are written while idle and leave ready high; ready is low while an evaluate runs.
// evaluate run time grows with the ns ship and nl landscape vertices and is
// set by the single shared 17x17 multiplier doing four products per segment
// pair; it ends early on the first hit.
// a result waits in the output register; the next evaluate waits in ST_DONE until it is taken.
// no clearing pass after reset: only loaded entries are ever read.
module polyline_segment_collision_core import psc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	psc_in_if.sink    vertex,
	psc_out_if.source result
);

	state_t state_q, state_d;

	store_ctrl_t        st_ctrl;
	store_stat_t        st_stat;
	mac_ctrl_t          mac_ctrl;
	logic [SHIP_AW-1:0] ship_raddr;
	coord_t             ship_rx, ship_ry, land_rx, land_ry;
	rel_t               op_a, op_b;
	cross_t             acc;

	logic [SHIP_AW-1:0] k_q;
	logic [LAND_AW-1:0] j_q;
	logic [SHIP_CW-1:0] ns_q;
	logic [LAND_CW-1:0] nl_q;
	logic               ovf_q, found_q;
	logic               out_valid_q, out_hit_q, out_ovf_q;

	coord_t ax_q, ay_q;
	rel_t   bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
	cross_t sc_q, sd_q;
	den_t   den_q;

	logic accept, is_eval, last_land, last_ship, out_free, pair_hit;
	den_t diff;
	logic excluded, straddle, on_seg;

	psc_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (st_ctrl),
		.wr_x       (vertex.x_coord),
		.wr_y       (vertex.y_coord),
		.ship_raddr (ship_raddr),
		.land_raddr (j_q),
		.ship_rx    (ship_rx),
		.ship_ry    (ship_ry),
		.land_rx    (land_rx),
		.land_ry    (land_ry),
		.stat       (st_stat)
	);

	psc_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	assign vertex.ready = (state_q == ST_IDLE);
	assign accept       = vertex.valid && vertex.ready;
	assign is_eval      = (vertex.command == CMD_EVAL);
	assign last_land    = (LAND_CW'(j_q) == nl_q - LAND_CW'(1));
	assign last_ship    = (SHIP_CW'(k_q) == ns_q - SHIP_CW'(1));
	assign out_free     = !out_valid_q || result.ready;

	// pair test on relative coordinates, cc sits in the accumulator
	assign diff     = den_q - den_t'(acc);
	assign excluded = (bx_q == '0 && by_q == '0) || (cx_q == dx_q && cy_q == dy_q)
		|| (cx_q == '0 && cy_q == '0) || (cx_q == bx_q && cy_q == by_q)
		|| (dx_q == '0 && dy_q == '0) || (dx_q == bx_q && dy_q == by_q);
	assign straddle = (sc_q[$bits(cross_t)-1] != sd_q[$bits(cross_t)-1]);
	assign on_seg   = den_q[$bits(den_t)-1]
		? ((acc[$bits(cross_t)-1] || acc == '0) && (diff[$bits(den_t)-1] || diff == '0))
		: (!acc[$bits(cross_t)-1] && !diff[$bits(den_t)-1]);
	assign pair_hit = !excluded && straddle && on_seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		st_ctrl         = '0;
		mac_ctrl.mul_en = 1'b0;
		mac_ctrl.acc_op = ACC_HOLD;
		op_a            = bx_q;
		op_b            = dy_q;
		ship_raddr      = k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (vertex.command)
						CMD_SHIP: st_ctrl.wr_ship = 1'b1;
						CMD_LAND: st_ctrl.wr_land = 1'b1;
						CMD_EVAL: begin
							st_ctrl.clear = 1'b1;
							if (st_stat.ship_count >= SHIP_CW'(2) &&
								st_stat.land_count >= LAND_CW'(2)) begin
								state_d = ST_SA_RD;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SA_RD: begin
				ship_raddr = k_q - SHIP_AW'(1);
				state_d    = ST_SB_RD;
			end
			ST_SB_RD: state_d = ST_SB_WT;
			ST_SB_WT: state_d = ST_L_RD;
			ST_L_RD:  state_d = ST_L_WT;
			ST_L_WT:  state_d = ST_SD1;
			ST_SD1: begin
				mac_ctrl.mul_en = 1'b1;
				state_d         = ST_SD2;
			end
			ST_SD2: begin
				mac_ctrl.mul_en = 1'b1;
				mac_ctrl.acc_op = ACC_LOAD;
				op_a            = by_q;
				op_b            = dx_q;
				state_d         = ST_SD3;
			end
			ST_SD3: begin
				mac_ctrl.acc_op = ACC_SUB;
				state_d         = ST_CAP;
			end
			// first landscape vertex only primes the side value
			ST_CAP: state_d = (j_q == '0) ? ST_NEXT : ST_CC1;
			ST_CC1: begin
				mac_ctrl.mul_en = 1'b1;
				op_a            = cx_q;
				state_d         = ST_CC2;
			end
			ST_CC2: begin
				mac_ctrl.mul_en = 1'b1;
				mac_ctrl.acc_op = ACC_LOAD;
				op_a            = cy_q;
				op_b            = dx_q;
				state_d         = ST_CC3;
			end
			ST_CC3: begin
				mac_ctrl.acc_op = ACC_SUB;
				state_d         = ST_EV1;
			end
			ST_EV1: state_d = ST_EV2;
			ST_EV2: state_d = pair_hit ? ST_DONE : ST_NEXT;
			ST_NEXT: begin
				if (!last_land) begin
					state_d = ST_L_RD;
				end else if (!last_ship) begin
					state_d = ST_SA_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// loop counters, captured counts and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			j_q         <= '0;
			ns_q        <= '0;
			nl_q        <= '0;
			ovf_q       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && is_eval) begin
				k_q     <= SHIP_AW'(1);
				ns_q    <= st_stat.ship_count;
				nl_q    <= st_stat.land_count;
				ovf_q   <= st_stat.dropped;
				found_q <= 1'b0;
			end
			if (state_q == ST_SB_WT) begin
				j_q <= '0;
			end
			if (state_q == ST_EV2 && pair_hit) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_NEXT) begin
				if (!last_land) begin
					j_q <= j_q + LAND_AW'(1);
				end else if (!last_ship) begin
					k_q <= k_q + SHIP_AW'(1);
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// geometry registers; the b, c and d vectors are relative to the ship segment start
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SB_RD: begin
				ax_q <= ship_rx;
				ay_q <= ship_ry;
			end
			ST_SB_WT: begin
				bx_q <= rel_t'(ship_rx) - rel_t'(ax_q);
				by_q <= rel_t'(ship_ry) - rel_t'(ay_q);
			end
			ST_L_WT: begin
				dx_q <= rel_t'(land_rx) - rel_t'(ax_q);
				dy_q <= rel_t'(land_ry) - rel_t'(ay_q);
			end
			ST_CAP: sd_q <= acc;
			ST_EV1: den_q <= den_t'(sd_q) - den_t'(sc_q);
			ST_NEXT: begin
				sc_q <= sd_q;
				cx_q <= dx_q;
				cy_q <= dy_q;
			end
			ST_DONE: begin
				if (out_free) begin
					out_hit_q <= found_q;
					out_ovf_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid    = out_valid_q;
	assign result.hit      = out_hit_q;
	assign result.overflow = out_ovf_q;

endmodule
